FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SPE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, with a message of the caller's choice.
`define SPE_ASSERT_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

FILE: rtl/core/spe_pkg.sv
// Types, codes and arithmetic helpers of the separable polynomial evaluator.
package spe_pkg;

  localparam int GOODS_DEF = 16;
  localparam int TERMS_DEF = 4;

  localparam int K_W    = 4;
  localparam int FACT_W = 8;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_UTIL = 2'd1;
  localparam logic [1:0] FUNC_D1   = 2'd2;
  localparam logic [1:0] FUNC_D2   = 2'd3;

  localparam logic [1:0] KIND_UTIL = 2'd0;
  localparam logic [1:0] KIND_D1   = 2'd1;
  localparam logic [1:0] KIND_D2   = 2'd2;

  localparam logic signed [31:0] ONE_Q16   = 32'sh0001_0000;
  localparam logic signed [63:0] SUM_LIMIT = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] MAX32     = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN32     = -64'sh0000_0000_8000_0000;

  typedef logic [K_W-1:0] k_t;

  typedef struct packed {
    logic load;     // store the coefficient on the input ports
    logic start;    // capture an evaluation item
    logic issue;    // read coefficient k and push it into the term pipeline
    k_t   k;
    logic upd;      // fold the item sum into the running utility sum
    logic fin;      // item complete
    logic out_load; // load the output register
  } spe_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } spe_sts_t;

  typedef struct packed {
    logic             clip;
    logic signed [31:0] val;
  } sat_t;

  // Q32.32 product to Q16.16 with round half up.
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + 64'sd32768;
    return t[63:16];
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    r.clip = 1'b0;
    r.val  = x[31:0];
    if (x > MAX32) begin
      r.clip = 1'b1;
      r.val  = MAX32[31:0];
    end else if (x < MIN32) begin
      r.clip = 1'b1;
      r.val  = MIN32[31:0];
    end
    return r;
  endfunction

  // Integer factor of term k: 1, k+1 or k*(k+1).
  function automatic logic [FACT_W-1:0] term_factor(input logic [1:0] func, input k_t k);
    logic [FACT_W-1:0] kx;
    logic [FACT_W-1:0] r;
    kx = FACT_W'(k);
    case (func)
      FUNC_UTIL: r = FACT_W'(1);
      FUNC_D1:   r = kx + FACT_W'(1);
      FUNC_D2:   r = kx * (kx + FACT_W'(1));
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] func_to_kind(input logic [1:0] func);
    logic [1:0] r;
    case (func)
      FUNC_UTIL: r = KIND_UTIL;
      FUNC_D1:   r = KIND_D1;
      FUNC_D2:   r = KIND_D2;
      default:   r = KIND_UTIL;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/spe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]              wdata_i,
  input  logic                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/spe_ctrl.sv
// Sequencer of the separable polynomial evaluator: accepts items, steps terms, hands off results.
module spe_ctrl #(
  parameter int TERMS = spe_pkg::TERMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic              last_good_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spe_pkg::spe_cmd_t cmd_o,
  input  spe_pkg::spe_sts_t sts_i
);

  localparam int KW = (TERMS > 1) ? $clog2(TERMS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic          emit_q, emit_d;
  logic          out_valid_q, out_valid_d;
  logic          in_xfer;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    emit_d   = emit_q;
    cmd_o    = '0;
    cmd_o.k  = spe_pkg::k_t'(k_q);
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (func_i == spe_pkg::FUNC_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            emit_d      = (func_i != spe_pkg::FUNC_UTIL) || last_good_i;
            // The second derivative starts at k = 1; with a single term it has none.
            if (func_i == spe_pkg::FUNC_D2) begin
              k_d     = KW'(1);
              state_d = (TERMS > 1) ? S_RUN : S_DRAIN;
            end else begin
              k_d     = '0;
              state_d = S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        if (k_q == KW'(TERMS - 1)) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!emit_q) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.fin      = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/spe_dpath.sv
// Datapath of the separable polynomial evaluator: coefficient store, term pipeline, sums.
module spe_dpath #(
  parameter int GOODS = spe_pkg::GOODS_DEF,
  parameter int TERMS = spe_pkg::TERMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic [1:0]         func_i,
  input  logic [3:0]         good_i,
  input  logic [3:0]         other_good_i,
  input  logic [1:0]         power_index_i,
  input  logic signed [31:0] coefficient_i,
  input  logic signed [31:0] quantity_i,
  input  logic               last_good_i,
  input  spe_pkg::spe_cmd_t  cmd_i,
  output spe_pkg::spe_sts_t  sts_o,
  output logic [1:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic               saturated_o
);

  localparam int Depth = GOODS * TERMS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Item captured at the start transfer.
  logic [1:0]         mode_q;
  logic [3:0]         good_q;
  logic signed [31:0] q_q;
  logic               last_q;
  logic               zero_q;

  logic signed [31:0] offset_q;

  // Coefficient store; an entry never written reads as zero.
  logic [Depth-1:0]   coef_vld_q;
  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic [31:0]        rdata;

  // Term pipeline.
  logic                       s1_vld_q, s2_vld_q, s3_vld_q;
  logic [spe_pkg::FACT_W-1:0] s1_fact_q, s2_fact_q;
  logic                       ent_vld_q;
  logic signed [31:0]         alpha;
  logic signed [31:0]         p_q;
  logic                       pclip_q;
  logic signed [63:0]         pmul, qmul;
  logic signed [63:0]         prod_q;
  logic signed [63:0]         term_q;
  spe_pkg::sat_t              p_next;

  logic signed [63:0] isum_q;
  logic               clip_item_q;
  logic signed [63:0] usum_q;
  logic               uclip_q;
  logic signed [63:0] usum_new;
  logic signed [63:0] total;
  spe_pkg::sat_t      res;

  logic [1:0]         kind_q;
  logic signed [31:0] value_q;
  logic               sat_q;

  assign we    = cmd_i.load && (int'(good_i) < GOODS) && (int'(power_index_i) < TERMS);
  assign waddr = AddrW'(int'(good_i) * TERMS + int'(power_index_i));
  assign raddr = AddrW'(int'(good_q) * TERMS + int'(cmd_i.k));

  spe_ram #(
    .WIDTH (32),
    .DEPTH (Depth)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (coefficient_i),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      offset_q   <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      usum_q     <= '0;
      uclip_q    <= 1'b0;
    end else begin
      if (we) begin
        coef_vld_q[waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (cmd_i.upd && (mode_q == spe_pkg::FUNC_UTIL)) begin
        usum_q  <= usum_new;
        uclip_q <= uclip_q || clip_item_q || (usum_new != usum_q + isum_q);
      end else if (cmd_i.fin && (mode_q == spe_pkg::FUNC_UTIL) && last_q) begin
        usum_q  <= '0;
        uclip_q <= 1'b0;
      end
    end
  end

  assign sts_o.pipe_busy = s1_vld_q || s2_vld_q || s3_vld_q;

  // Unwritten entries, goods out of range and mismatched D2 goods all read as zero.
  assign alpha  = (zero_q || !ent_vld_q) ? 32'sd0 : rdata;
  assign pmul   = 64'(alpha) * 64'(p_q);
  assign qmul   = 64'(p_q) * 64'(q_q);
  assign p_next = spe_pkg::sat32(64'(spe_pkg::rnd16(qmul)));

  always_comb begin
    logic signed [63:0] s;
    s = usum_q + isum_q;
    usum_new = s;
    if (s > spe_pkg::SUM_LIMIT) begin
      usum_new = spe_pkg::SUM_LIMIT;
    end else if (s < -spe_pkg::SUM_LIMIT) begin
      usum_new = -spe_pkg::SUM_LIMIT;
    end
  end

  assign total = (mode_q == spe_pkg::FUNC_UTIL) ? (64'(offset_q) + usum_q) : isum_q;
  assign res   = spe_pkg::sat32(total);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q      <= func_i;
      good_q      <= good_i;
      q_q         <= quantity_i;
      last_q      <= last_good_i;
      zero_q      <= (int'(good_i) >= GOODS) ||
                     ((func_i == spe_pkg::FUNC_D2) && (good_i != other_good_i));
      // The utility series starts at q^1, the derivatives at q^0.
      p_q         <= (func_i == spe_pkg::FUNC_UTIL) ? quantity_i : spe_pkg::ONE_Q16;
      pclip_q     <= 1'b0;
      clip_item_q <= 1'b0;
      isum_q      <= '0;
    end else begin
      if (s1_vld_q) begin
        prod_q      <= pmul;
        p_q         <= p_next.val;
        pclip_q     <= pclip_q || p_next.clip;
        clip_item_q <= clip_item_q || ((alpha != 32'sd0) && pclip_q);
      end
      if (s3_vld_q) begin
        isum_q <= isum_q + term_q;
      end
    end
    if (cmd_i.issue) begin
      ent_vld_q <= coef_vld_q[raddr];
      s1_fact_q <= spe_pkg::term_factor(mode_q, cmd_i.k);
    end
    if (s1_vld_q) begin
      s2_fact_q <= s1_fact_q;
    end
    if (s2_vld_q) begin
      term_q <= 64'(spe_pkg::rnd16(prod_q)) * 64'($signed({1'b0, s2_fact_q}));
    end
    if (cmd_i.out_load) begin
      kind_q  <= spe_pkg::func_to_kind(mode_q);
      value_q <= res.val;
      sat_q   <= res.clip || ((mode_q == spe_pkg::FUNC_UTIL) ? uclip_q : clip_item_q);
    end
  end

  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign saturated_o = sat_q;

endmodule

FILE: rtl/core/separable_polynomial_eval.sv
// Top level of the separable polynomial evaluator with first and second derivatives.
//
//   channel  direction  transfer when            payload
//   in       input      in_valid_i & in_ready_o  func, good, other_good, power_index,
//                                                coefficient, quantity, last_good
//   out      output     out_valid_o & out_ready_i  kind, value, saturated
//   cfg      input      cfg_we_i                 cfg_wdata_i (utility offset)
//
// After a load item the next item can be taken in the following cycle. Any other item
// is worked through before the next item is taken: one coefficient read a cycle through
// the term pipeline (from k = 1 for a second derivative), a drain of the pipeline, one
// sum update and one hand-off. A waiting result does not block the next item from being
// taken; that item's hand-off waits for the output register to be free, with no new item
// taken meanwhile. Reset clears all coefficients and the running utility sum.
module separable_polynomial_eval #(
  parameter int GOODS = spe_pkg::GOODS_DEF,
  parameter int TERMS = spe_pkg::TERMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [3:0]         good_i,
  input  logic [3:0]         other_good_i,
  input  logic [1:0]         power_index_i,
  input  logic signed [31:0] coefficient_i,
  input  logic signed [31:0] quantity_i,
  input  logic               last_good_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic               saturated_o
);

  spe_pkg::spe_cmd_t cmd;
  spe_pkg::spe_sts_t sts;

  spe_ctrl #(
    .TERMS (TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .last_good_i (last_good_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  spe_dpath #(
    .GOODS (GOODS),
    .TERMS (TERMS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .good_i        (good_i),
    .other_good_i  (other_good_i),
    .power_index_i (power_index_i),
    .coefficient_i (coefficient_i),
    .quantity_i    (quantity_i),
    .last_good_i   (last_good_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .saturated_o   (saturated_o)
  );

endmodule

FILE: rtl/core/spe_checker.sv
// Port-level checks of the separable polynomial evaluator and their binding.
`include "assert_macros.svh"

module spe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  func_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [31:0] value_i,
  input logic        saturated_i
);

  `SPE_ASSERT_MSG(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(kind_i) && $stable(value_i) && $stable(saturated_i)), "stalled result changed")
  `SPE_ASSERT(a_load_single_cycle, clk_i, rst_ni, (in_valid_i && in_ready_i && (func_i == spe_pkg::FUNC_LOAD)) |=> in_ready_i)
  `SPE_ASSERT(a_eval_busy, clk_i, rst_ni, (in_valid_i && in_ready_i && (func_i != spe_pkg::FUNC_LOAD)) |=> !in_ready_i)
  `SPE_ASSERT_MSG(a_result_after_work, clk_i, rst_ni, $rose(out_valid_i) |-> ($past(!in_ready_i) && (kind_i != 2'd3)), "result without finished item")

endmodule

bind separable_polynomial_eval spe_checker u_spe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .func_i      (func_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_i      (kind_o),
  .value_i     (value_o),
  .saturated_i (saturated_o)
);

FILE: tb/sv/separable_polynomial_eval_tb.sv
// Testbench for the separable polynomial evaluator: directed and random items against a predictor.
module separable_polynomial_eval_tb;
  import spe_pkg::*;

  localparam int N_GOODS     = 16;
  localparam int N_TERMS     = 4;
  localparam int SETTLE      = 20;
  localparam int HOLD_LEN    = 300;
  localparam int CLAMP_ITEMS = 6;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_TWO = 32'sh0002_0000;

  typedef struct {
    logic [1:0]         func;
    logic [3:0]         good;
    logic [3:0]         other;
    logic [1:0]         pidx;
    logic signed [31:0] coef;
    logic signed [31:0] qty;
    logic               last;
  } item_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic               sat;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func_i = FUNC_LOAD;
  logic [3:0]         good_i = '0;
  logic [3:0]         other_good_i = '0;
  logic [1:0]         power_index_i = '0;
  logic signed [31:0] coefficient_i = '0;
  logic signed [31:0] quantity_i = '0;
  logic               last_good_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic signed [31:0] value_o;
  logic               saturated_o;

  // Predictor state, mirroring the block after reset.
  logic signed [31:0] coef_mem [N_GOODS*N_TERMS] = '{default: '0};
  longint             util_acc = 0;
  bit                 util_acc_clip = 1'b0;
  logic signed [31:0] offset_q = '0;
  result_t            expected_q[$];

  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   ready_stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  separable_polynomial_eval u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .good_i        (good_i),
    .other_good_i  (other_good_i),
    .power_index_i (power_index_i),
    .coefficient_i (coefficient_i),
    .quantity_i    (quantity_i),
    .last_good_i   (last_good_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .saturated_o   (saturated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("separable_polynomial_eval_tb failed");
    $finish;
  end

  // Q32.32 product to Q16.16, rounding half up.
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic int clip_to_int(input longint x, inout bit hit);
    if (x > 64'sd2147483647) begin
      hit = 1'b1;
      return Q_MAX;
    end
    if (x < -64'sd2147483648) begin
      hit = 1'b1;
      return Q_MIN;
    end
    return int'(x);
  endfunction

  // Term sum of one good; the power q^e is built one multiply at a time, and once
  // a power clips every higher power counts as clipped.
  function automatic longint term_sum(input logic [1:0] fn, input logic [3:0] g,
                                      input int q, inout bit hit);
    longint acc;
    longint mult;
    int     p;
    int     e_now;
    int     e;
    int     a;
    int     k;
    bit     p_hit;
    acc = 0;
    p = ONE_Q16;
    e_now = 0;
    p_hit = 1'b0;
    for (k = (fn == FUNC_D2) ? 1 : 0; k < N_TERMS; k++) begin
      case (fn)
        FUNC_UTIL: begin
          e = k + 1;
          mult = 1;
        end
        FUNC_D1: begin
          e = k;
          mult = longint'(k + 1);
        end
        default: begin
          e = k - 1;
          mult = longint'(k * (k + 1));
        end
      endcase
      a = coef_mem[g * N_TERMS + k];
      while (e_now < e) begin
        p = clip_to_int(round_q16(longint'(p) * longint'(q)), p_hit);
        e_now++;
      end
      if (a != 0 && p_hit) hit = 1'b1;
      acc += round_q16(longint'(a) * longint'(p)) * mult;
    end
    return acc;
  endfunction

  task automatic predict_item(input item_t it);
    result_t r;
    longint  total;
    bit      hit;
    bit      emit;
    hit = 1'b0;
    emit = 1'b0;
    total = 0;
    case (it.func)
      FUNC_LOAD: coef_mem[it.good * N_TERMS + it.pidx] = it.coef;
      FUNC_UTIL: begin
        util_acc += term_sum(FUNC_UTIL, it.good, it.qty, hit);
        util_acc_clip |= hit;
        if (util_acc > SUM_LIMIT) begin
          util_acc = SUM_LIMIT;
          util_acc_clip = 1'b1;
        end else if (util_acc < -SUM_LIMIT) begin
          util_acc = -SUM_LIMIT;
          util_acc_clip = 1'b1;
        end
        if (it.last) begin
          total = longint'(offset_q) + util_acc;
          hit = util_acc_clip;
          util_acc = 0;
          util_acc_clip = 1'b0;
          r.kind = KIND_UTIL;
          emit = 1'b1;
        end
      end
      FUNC_D1: begin
        total = term_sum(FUNC_D1, it.good, it.qty, hit);
        r.kind = KIND_D1;
        emit = 1'b1;
      end
      default: begin
        if (it.good == it.other) total = term_sum(FUNC_D2, it.good, it.qty, hit);
        r.kind = KIND_D2;
        emit = 1'b1;
      end
    endcase
    if (emit) begin
      r.value = clip_to_int(total, hit);
      r.sat = hit;
      expected_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d value %0d", kind_o, value_o));
    end else begin
      want = expected_q.pop_front();
      if (kind_o !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
      if (value_o !== want.value)
        report_mismatch($sformatf("value %0d, want %0d", value_o, want.value));
      if (saturated_o !== want.sat)
        report_mismatch($sformatf("saturated %0b, want %0b", saturated_o, want.sat));
    end
  endtask

  // Result check, register tracking and prediction, all on values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result();
      if (cfg_we_i) offset_q = cfg_wdata_i;
      if (in_valid_i && in_ready_o)
        predict_item('{func: func_i, good: good_i, other: other_good_i,
                       pidx: power_index_i, coef: coefficient_i, qty: quantity_i,
                       last: last_good_i});
    end
  end

  // Output side: random stalls, or a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  function automatic item_t item(input logic [1:0] fn, input logic [3:0] g,
                                 input logic [3:0] og, input logic [1:0] k,
                                 input logic signed [31:0] c, input logic signed [31:0] q,
                                 input logic last);
    item_t it;
    it.func = fn;
    it.good = g;
    it.other = og;
    it.pidx = k;
    it.coef = c;
    it.qty = q;
    it.last = last;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return Q_MAX;
      3:       return Q_MIN;
      4:       return '0;
      5:       return ($urandom_range(1) != 0) ? ONE_Q16 : -ONE_Q16;
      default: return $urandom_range(393216) - 196608;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // Noise: every field at random.
      it = item(2'($urandom), 4'($urandom), 4'($urandom), 2'($urandom), $urandom,
                $urandom, 1'($urandom));
    end else begin
      it.good = 4'($urandom_range(N_GOODS - 1));
      it.other = ($urandom_range(99) < 70) ? it.good : 4'($urandom);
      it.pidx = 2'($urandom);
      it.coef = rand_q16();
      it.qty = rand_q16();
      it.last = ($urandom_range(99) < 30);
      pick = $urandom_range(99);
      it.func = (pick < 25) ? FUNC_LOAD : (pick < 65) ? FUNC_UTIL :
                (pick < 80) ? FUNC_D1 : FUNC_D2;
    end
    return it;
  endfunction

  // Valid stays high from one item to the next unless the sender idles; callers
  // follow a send with another send or with wait_idle.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= it.func;
    good_i <= it.good;
    other_good_i <= it.other;
    power_index_i <= it.pidx;
    coefficient_i <= it.coef;
    quantity_i <= it.qty;
    last_good_i <= it.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop sending until every expected result is back and the pipeline has drained.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic signed [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    ready_stall_pct = 0;
    write_offset(32'sh0002_8000);
    // Unused fields on loads carry odd values; they must not matter.
    send_item(item(FUNC_LOAD, 4'd0, 4'd15, 2'd0, ONE_Q16, Q_MIN, 1'b1));
    send_item(item(FUNC_LOAD, 4'd0, 4'd0, 2'd1, Q_TWO, Q_MAX, 1'b0));
    send_item(item(FUNC_LOAD, 4'd0, 4'd0, 2'd2, 32'shffff_8000, '0, 1'b0));
    send_item(item(FUNC_LOAD, 4'd0, 4'd0, 2'd3, 32'sh0000_4000, '0, 1'b1));
    send_item(item(FUNC_UTIL, 4'd0, 4'd7, 2'd3, Q_MAX, 32'sh0001_8000, 1'b0));
    send_item(item(FUNC_UTIL, 4'd1, 4'd0, 2'd0, '0, Q_MAX, 1'b1));
    send_item(item(FUNC_D1, 4'd0, 4'd3, 2'd2, Q_MIN, Q_TWO, 1'b1));
    send_item(item(FUNC_D2, 4'd0, 4'd0, 2'd0, '0, 32'shfffe_8000, 1'b0));
    send_item(item(FUNC_D2, 4'd0, 4'd9, 2'd0, '0, ONE_Q16, 1'b0));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd0, Q_MIN, '0, 1'b0));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd3, Q_MAX, '0, 1'b0));
    send_item(item(FUNC_D1, 4'd15, 4'd0, 2'd0, '0, Q_MAX, 1'b0));
    send_item(item(FUNC_D2, 4'd15, 4'd15, 2'd0, '0, Q_MIN, 1'b0));
    send_item(item(FUNC_D2, 4'd5, 4'd0, 2'd0, '0, Q_MIN, 1'b1));
    // A clipped power makes the whole bundle sticky-saturated.
    send_item(item(FUNC_UTIL, 4'd15, 4'd0, 2'd0, '0, Q_MIN, 1'b0));
    send_item(item(FUNC_UTIL, 4'd0, 4'd0, 2'd0, '0, ONE_Q16, 1'b1));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd0, '0, '0, 1'b0));
    send_item(item(FUNC_UTIL, 4'd0, 4'd0, 2'd0, '0, '0, 1'b1));
    send_item(item(FUNC_D1, 4'd7, 4'd7, 2'd0, '0, '0, 1'b0));
    wait_idle();
    write_offset(Q_MAX);
    send_item(item(FUNC_UTIL, 4'd0, 4'd0, 2'd0, '0, 32'sh0003_0000, 1'b1));
    wait_idle();
  endtask

  // Drives the running sum far outside the result range, once upward and once downward.
  task automatic test_sum_clamp();
    int i;
    send_idle_pct = 0;
    ready_stall_pct = 0;
    write_offset(Q_MIN);
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd0, Q_MIN, '0, 1'b0));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd1, Q_MAX, '0, 1'b0));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd2, Q_MIN, '0, 1'b0));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd3, Q_MAX, '0, 1'b0));
    for (i = 0; i < CLAMP_ITEMS; i++)
      send_item(item(FUNC_UTIL, 4'd15, 4'd0, 2'd0, '0, Q_MIN, 1'b0));
    send_item(item(FUNC_UTIL, 4'd15, 4'd0, 2'd0, '0, Q_MIN, 1'b1));
    wait_idle();
    write_offset('0);
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd0, Q_MAX, '0, 1'b0));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd1, Q_MIN, '0, 1'b0));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd2, Q_MAX, '0, 1'b0));
    send_item(item(FUNC_LOAD, 4'd15, 4'd0, 2'd3, Q_MIN, '0, 1'b0));
    for (i = 0; i < CLAMP_ITEMS; i++)
      send_item(item(FUNC_UTIL, 4'd15, 4'd0, 2'd0, '0, Q_MIN, 1'b0));
    send_item(item(FUNC_UTIL, 4'd15, 4'd0, 2'd0, '0, Q_MIN, 1'b1));
    wait_idle();
  endtask

  // The output is held off for a long stretch while items keep coming, so the
  // block has to stop taking input transfers.
  task automatic test_backpressure();
    item_t it;
    int    i;
    send_idle_pct = 0;
    ready_stall_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    for (i = 0; i < 40; i++) begin
      it = rand_item();
      it.func = (i % 2 == 0) ? FUNC_D1 : FUNC_D2;
      send_item(it);
    end
    wait_idle();
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    int i;
    send_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    for (i = 0; i < n; i++) begin
      send_item(rand_item());
      if (i % 128 == 127) begin
        wait_idle();
        write_offset(rand_q16());
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_sum_clamp();
    test_backpressure();
    test_random(355, 11, 82);
    test_random(355, 82, 11);
    test_random(355, 0, 0);
    if (fail_count == 0)
      $display("separable_polynomial_eval_tb passed");
    else
      $display("separable_polynomial_eval_tb failed");
    $finish;
  end

endmodule
